/* sv/bimo_pkg.sv */
// Shared types and constants for the binary image moment block.
// No dependencies; every other source file uses this package.
package bimo_pkg;

  // largest frame; the sum widths below are sized for it
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W  = 11;
  localparam int AREA_W = 21;
  localparam int SR_W   = 31;
  localparam int SC_W   = 30;
  localparam int SRR_W  = 41;
  localparam int SCC_W  = 40;
  localparam int SRC_W  = 41;
  localparam int CEN_W  = 19;
  localparam int ORI_W  = 15;
  localparam int ANG_W  = 27;
  localparam int CORDIC_STEPS = 24;

  localparam logic [ANG_W-1:0] HALF_PI_Q24    = ANG_W'(26353589);
  localparam logic [ORI_W-1:0] QUARTER_PI_Q14 = ORI_W'(12868);

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [SR_W-1:0]   sum_row;
    logic [SC_W-1:0]   sum_col;
    logic [SRR_W-1:0]  sum_row_sq;
    logic [SCC_W-1:0]  sum_col_sq;
    logic [SRC_W-1:0]  sum_row_col;
  } moments_t;

  function automatic logic [ANG_W-1:0] atan_q24(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = ANG_W'(13176795);
      5'd1:  v = ANG_W'(7778716);
      5'd2:  v = ANG_W'(4110060);
      5'd3:  v = ANG_W'(2086331);
      5'd4:  v = ANG_W'(1047214);
      5'd5:  v = ANG_W'(524117);
      5'd6:  v = ANG_W'(262123);
      5'd7:  v = ANG_W'(131069);
      5'd8:  v = ANG_W'(65536);
      5'd9:  v = ANG_W'(32768);
      5'd10: v = ANG_W'(16384);
      5'd11: v = ANG_W'(8192);
      5'd12: v = ANG_W'(4096);
      5'd13: v = ANG_W'(2048);
      5'd14: v = ANG_W'(1024);
      5'd15: v = ANG_W'(512);
      5'd16: v = ANG_W'(256);
      5'd17: v = ANG_W'(128);
      5'd18: v = ANG_W'(64);
      5'd19: v = ANG_W'(32);
      5'd20: v = ANG_W'(16);
      5'd21: v = ANG_W'(8);
      5'd22: v = ANG_W'(4);
      5'd23: v = ANG_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/bimo_if.sv */
// Handshake channels of the moment block: pixel stream in, result out.
// Depends on bimo_pkg for field widths.
interface bimo_pix_if;
  logic valid;
  logic ready;
  logic pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bimo_res_if;
  logic                           valid;
  logic                           ready;
  logic [bimo_pkg::AREA_W-1:0]    area;
  logic [bimo_pkg::CEN_W-1:0]     centroid_row;
  logic [bimo_pkg::CEN_W-1:0]     centroid_col;
  logic signed [bimo_pkg::ORI_W-1:0] orientation;
  logic                           empty_frame;
  logic                           angle_undefined;
  modport source (output valid, output area, output centroid_row, output centroid_col,
                  output orientation, output empty_frame, output angle_undefined,
                  input ready);
  modport sink   (input valid, input area, input centroid_row, input centroid_col,
                  input orientation, input empty_frame, input angle_undefined,
                  output ready);
endinterface

/* sv/bimo_accum.sv */
// Front end: raster counters and raw moment accumulation, one pixel a cycle while the queue is not full.
// Depends on bimo_pkg; pushes finished frame sums into bimo_fifo.
module bimo_accum #(
  parameter int CW = 10,
  parameter int DW = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DW-1:0]       width_i,
  input  logic [DW-1:0]       height_i,
  input  logic                pix_valid_i,
  input  logic                pix_i,
  output logic                pix_ready_o,
  input  logic                full_i,
  output logic                push_o,
  output bimo_pkg::moments_t  push_data_o
);
  import bimo_pkg::*;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  moments_t      acc_q, acc_d;
  logic          take, col_end, row_end;
  logic [DW-1:0] yv;
  logic [DW-1:0] xv;

  assign pix_ready_o = !full_i;
  assign take        = pix_valid_i && !full_i;
  assign col_end     = (32'(col_q) + 32'd1) >= 32'(width_i);
  assign row_end     = (32'(row_q) + 32'd1) >= 32'(height_i);
  assign yv = (32'(row_q) < 32'(height_i)) ? DW'(32'(height_i) - 32'(row_q)) : DW'(1);
  assign xv = DW'(col_q);

  always_comb begin
    acc_d = acc_q;
    col_d = col_q;
    row_d = row_q;
    if (pix_i) begin
      acc_d.area        = acc_q.area + AREA_W'(1);
      acc_d.sum_row     = acc_q.sum_row + SR_W'(yv);
      acc_d.sum_col     = acc_q.sum_col + SC_W'(xv);
      acc_d.sum_row_sq  = acc_q.sum_row_sq + SRR_W'(yv) * SRR_W'(yv);
      acc_d.sum_col_sq  = acc_q.sum_col_sq + SCC_W'(xv) * SCC_W'(xv);
      acc_d.sum_row_col = acc_q.sum_row_col + SRC_W'(yv) * SRC_W'(xv);
    end
    if (col_end) begin
      col_d = '0;
      if (!row_end) row_d = row_q + CW'(1);
      else          row_d = '0;
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  assign push_o      = take && col_end && row_end;
  assign push_data_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      acc_q <= '0;
    end else if (take) begin
      col_q <= col_d;
      row_q <= row_d;
      // clear the sums once the frame is handed over
      acc_q <= push_o ? '0 : acc_d;
    end
  end
endmodule

/* sv/bimo_fifo.sv */
// Two-entry queue of frame moment sets between front and back end.
// Depends on bimo_pkg for the entry type.
module bimo_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bimo_pkg::moments_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output bimo_pkg::moments_t pop_data_o
);
  import bimo_pkg::*;

  moments_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

/* sv/bimo_math.sv */
// Back end: central moments, centroid division and CORDIC angle, all serial.
// Depends on bimo_pkg; drains bimo_fifo and drives the result channel.
module bimo_math (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  bimo_pkg::moments_t    data_i,
  output logic                  pop_o,
  bimo_res_if.source            res
);
  import bimo_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MACC, ST_DIV, ST_PREP, ST_NORM, ST_CORD, ST_DONE
  } state_e;

  state_e          state_q;
  moments_t        m_q;
  logic [2:0]      k_q;
  logic [5:0]      cnt_q;
  logic [63:0]     prod_q, mcand_q;
  logic [31:0]     mult_q;
  logic signed [63:0] nrr_q, ncc_q, nrc_q, num_q, den_q;
  logic [39:0]     dn_q;
  logic [21:0]     rem_q;
  logic [CEN_W-1:0] cen_row_q, cen_col_q;
  logic [63:0]     mx_q, my_q;
  logic signed [63:0] x_q, y_q;
  logic signed [ANG_W-1:0] z_q;
  logic            neg_q;
  logic            out_valid_q;

  logic [31:0]     op_a;
  logic [63:0]     op_b;
  logic [21:0]     rem_sh;
  logic            ge;
  logic signed [63:0] dx, dy;
  logic signed [ANG_W-1:0] zc;
  logic [ANG_W-1:0] zr;
  logic [ORI_W-1:0] ang;

  always_comb begin
    unique case (k_q)
      3'd0:    begin op_a = 32'(m_q.area);    op_b = 64'(m_q.sum_row_sq);  end
      3'd1:    begin op_a = 32'(m_q.sum_row); op_b = 64'(m_q.sum_row);     end
      3'd2:    begin op_a = 32'(m_q.area);    op_b = 64'(m_q.sum_col_sq);  end
      3'd3:    begin op_a = 32'(m_q.sum_col); op_b = 64'(m_q.sum_col);     end
      3'd4:    begin op_a = 32'(m_q.area);    op_b = 64'(m_q.sum_row_col); end
      default: begin op_a = 32'(m_q.sum_col); op_b = 64'(m_q.sum_row);     end
    endcase
  end

  assign rem_sh = {rem_q[20:0], dn_q[39]};
  assign ge     = rem_sh >= 22'(m_q.area);
  assign dx     = y_q >>> cnt_q[4:0];
  assign dy     = x_q >>> cnt_q[4:0];
  assign zc     = z_q[ANG_W-1] ? '0 :
                  (z_q > $signed(HALF_PI_Q24)) ? $signed(HALF_PI_Q24) : z_q;
  assign zr     = ANG_W'(zc + ANG_W'(1024)) >> 11;
  assign ang    = ORI_W'(zr);

  assign pop_o = (state_q == ST_IDLE) && valid_i && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= ST_IDLE;
      out_valid_q         <= 1'b0;
      k_q                 <= '0;
      cnt_q               <= '0;
      res.area            <= '0;
      res.centroid_row    <= '0;
      res.centroid_col    <= '0;
      res.orientation     <= '0;
      res.empty_frame     <= 1'b0;
      res.angle_undefined <= 1'b0;
    end else begin
      if (res.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            m_q <= data_i;
            if (data_i.area == '0) begin
              // empty frame: report flag only
              res.area            <= '0;
              res.centroid_row    <= '0;
              res.centroid_col    <= '0;
              res.orientation     <= '0;
              res.empty_frame     <= 1'b1;
              res.angle_undefined <= 1'b0;
              out_valid_q         <= 1'b1;
            end else begin
              k_q     <= '0;
              cnt_q   <= '0;
              prod_q  <= '0;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // shift-add multiply, one multiplier bit a cycle
          if (cnt_q == '0) begin
            mult_q  <= op_a >> 1;
            mcand_q <= op_b << 1;
            prod_q  <= op_a[0] ? op_b : '0;
          end else begin
            mult_q  <= mult_q >> 1;
            mcand_q <= mcand_q << 1;
            if (mult_q[0]) prod_q <= prod_q + mcand_q;
          end
          if (cnt_q == 6'd31) state_q <= ST_MACC;
          cnt_q <= cnt_q + 6'd1;
        end
        ST_MACC: begin
          case (k_q)
            3'd0: nrr_q <= prod_q;
            3'd1: nrr_q <= nrr_q - prod_q;
            3'd2: ncc_q <= prod_q;
            3'd3: ncc_q <= ncc_q - prod_q;
            3'd4: nrc_q <= prod_q;
            default: nrc_q <= nrc_q - prod_q;
          endcase
          cnt_q <= '0;
          if (k_q == 3'd5) begin
            k_q     <= '0;
            dn_q    <= {m_q.sum_row, 8'd0} + 40'(m_q.area >> 1);
            rem_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= ST_MUL;
          end
        end
        ST_DIV: begin
          // restoring division, quotient bits shift into dn_q
          rem_q <= ge ? rem_sh - 22'(m_q.area) : rem_sh;
          dn_q  <= {dn_q[38:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd39) begin
            cnt_q <= '0;
            rem_q <= '0;
            if (k_q == 3'd0) begin
              cen_row_q <= CEN_W'({dn_q[38:0], ge});
              dn_q      <= {m_q.sum_col, 8'd0} + 40'(m_q.area >> 1);
              k_q       <= 3'd1;
            end else begin
              cen_col_q <= CEN_W'({dn_q[38:0], ge});
              num_q     <= nrc_q <<< 1;
              den_q     <= nrr_q - ncc_q;
              state_q   <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          res.area         <= m_q.area;
          res.centroid_row <= cen_row_q;
          res.centroid_col <= cen_col_q;
          res.empty_frame  <= 1'b0;
          if (num_q == '0 && den_q == '0) begin
            res.orientation     <= '0;
            res.angle_undefined <= 1'b1;
            out_valid_q         <= 1'b1;
            state_q             <= ST_DONE;
          end else if (den_q == '0) begin
            res.orientation     <= num_q[63] ? -$signed(QUARTER_PI_Q14)
                                             : $signed(QUARTER_PI_Q14);
            res.angle_undefined <= 1'b0;
            out_valid_q         <= 1'b1;
            state_q             <= ST_DONE;
          end else begin
            res.angle_undefined <= 1'b0;
            mx_q    <= den_q[63] ? 64'(-den_q) : 64'(den_q);
            my_q    <= num_q[63] ? 64'(-num_q) : 64'(num_q);
            neg_q   <= num_q[63] != den_q[63];
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          // bring both magnitudes under 2^60
          if (mx_q[63:60] != '0 || my_q[63:60] != '0) begin
            mx_q <= mx_q >> 1;
            my_q <= my_q >> 1;
          end else begin
            x_q     <= $signed(mx_q);
            y_q     <= $signed(my_q);
            z_q     <= '0;
            cnt_q   <= '0;
            state_q <= ST_CORD;
          end
        end
        ST_CORD: begin
          if (!y_q[63]) begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + $signed(atan_q24(cnt_q[4:0]));
          end else begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - $signed(atan_q24(cnt_q[4:0]));
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(CORDIC_STEPS)) begin
            res.orientation <= neg_q ? -$signed(ang) : $signed(ang);
            out_valid_q     <= 1'b1;
            cnt_q           <= '0;
            state_q         <= ST_DONE;
          end
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res.valid = out_valid_q;
endmodule

/* sv/binary_image_moment_orientation.sv */
// Binary image moments: area, centroid and axis of least inertia per frame.
// Pixels are taken one per cycle; ready drops only while both queued frame slots are full.
// Frame-end math is serial (shift-add multiplies, two 40-step divisions,
// normalize, CORDIC steps); an empty frame is reported the cycle after it is popped.
// Reset (async, active low) clears counters, sums, queue and output; dimensions go to 1024.
module binary_image_moment_orientation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bimo_pkg::CFG_W-1:0]  cfg_data_i,
  bimo_pix_if.sink                    pix,
  bimo_res_if.source                  res
);
  import bimo_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int DW = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);

  logic [CFG_W-1:0] width_q, height_q;
  logic [DW-1:0]    w_eff, h_eff;
  logic             full, push, qvalid, pop;
  moments_t         push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1024);
      height_q <= CFG_W'(1024);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_WIDTH) width_q  <= cfg_data_i;
      else                            height_q <= cfg_data_i;
    end
  end

  // zero reads as one, anything above the maximum is clamped
  assign w_eff = (width_q == '0) ? DW'(1) :
                 (32'(width_q) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(width_q);
  assign h_eff = (height_q == '0) ? DW'(1) :
                 (32'(height_q) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : DW'(height_q);

  bimo_accum #(.CW(CW), .DW(DW)) u_accum (
    .clk_i, .rst_ni,
    .width_i     (w_eff),
    .height_i    (h_eff),
    .pix_valid_i (pix.valid),
    .pix_i       (pix.pixel),
    .pix_ready_o (pix.ready),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bimo_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qvalid),
    .pop_data_o  (pop_data)
  );

  bimo_math u_math (
    .clk_i, .rst_ni,
    .valid_i (qvalid),
    .data_i  (pop_data),
    .pop_o   (pop),
    .res     (res)
  );
endmodule

/* sim/binary_image_moment_orientation_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for binary_image_moment_orientation: drives pixel frames and
// config writes, predicts each frame's moments result and checks it field by field.
// Depends on bimo_pkg, bimo_pix_if / bimo_res_if and the block itself.
module binary_image_moment_orientation_tb;
  import bimo_pkg::*;

  localparam int MAX_DIM      = 1024;
  localparam int SETTLE_CYC   = 350;    // frame-end math latency with margin
  localparam int HOLD_CYC     = 3000;   // long receiver back-pressure stretch
  localparam int WATCHDOG_CYC = 20000;  // cycles without any transaction
  localparam int ITEM_GOAL    = 1400;
  localparam int CALM_AFTER   = 1200;   // no idling after this many pixels
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [2:0] {FILL_ZERO, FILL_ONE, FILL_DIAG, FILL_ANTI, FILL_RAND} fill_e;

  typedef struct packed {
    logic [AREA_W-1:0]       area;
    logic [CEN_W-1:0]        centroid_row;
    logic [CEN_W-1:0]        centroid_col;
    logic signed [ORI_W-1:0] orientation;
    logic                    empty_frame;
    logic                    angle_undefined;
  } moment_rec_t;

  typedef struct {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    fill_e            fill;
    bit               typed;
    moment_rec_t      rec;
  } frame_row_t;

  // atan(2^-i) in Q.24
  localparam longint ATAN_Q24 [CORDIC_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  bimo_pix_if pix_ch ();
  bimo_res_if res_ch ();

  binary_image_moment_orientation u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix        (pix_ch),
    .res        (res_ch)
  );

  // Predictor state: configuration and per-frame accumulators.
  logic [CFG_W-1:0]  cur_width, cur_height;
  int unsigned       col_pos, row_pos;
  longint unsigned   obj_area, s_row, s_col, s_row_sq, s_col_sq, s_row_col;

  moment_rec_t       frame_results_q[$];
  bit                typed_pending;
  moment_rec_t       typed_rec;
  bit                calm;
  bit                hold_req;
  int                mismatches;
  int                pixels_sent;
  int                idle_cycles;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic int unsigned dim_eff(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // Append one expectation at the tail of the result queue.
  function automatic void queue_expected(moment_rec_t r);
    frame_results_q = {frame_results_q, r};
  endfunction

  // Axis of least inertia from the scaled central moment terms.
  function automatic logic signed [ORI_W-1:0] axis_angle(longint num, longint den);
    longint unsigned mx, my;
    longint          x, y, z, dx, dy, ang;
    mx = (den < 0) ? (64'd0 - longint'(den)) : den;
    my = (num < 0) ? (64'd0 - longint'(num)) : num;
    while (mx >= (64'd1 << 60) || my >= (64'd1 << 60)) begin
      mx = mx >> 1;
      my = my >> 1;
    end
    x = mx;
    y = my;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q24[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q24[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q24)) z = longint'(HALF_PI_Q24);
    ang = (z + 1024) >>> 11;
    if ((num < 0) != (den < 0)) ang = -ang;
    return ORI_W'(ang);
  endfunction

  function automatic moment_rec_t frame_summary();
    moment_rec_t     r;
    longint unsigned a, nrr_u, ncc_u, nrc_u;
    longint          num, den;
    r = '0;
    a = obj_area;
    if (a == 0) begin
      r.empty_frame = 1'b1;
      return r;
    end
    r.area         = AREA_W'(a);
    r.centroid_row = CEN_W'((s_row * 256 + a / 2) / a);
    r.centroid_col = CEN_W'((s_col * 256 + a / 2) / a);
    nrr_u = a * s_row_sq - s_row * s_row;
    ncc_u = a * s_col_sq - s_col * s_col;
    nrc_u = a * s_row_col - s_row * s_col;
    num = longint'(nrc_u * 2);
    den = longint'(nrr_u - ncc_u);
    if (num == 0 && den == 0) begin
      r.angle_undefined = 1'b1;
    end else if (den == 0) begin
      r.orientation = (num > 0) ? $signed(QUARTER_PI_Q14) : -$signed(QUARTER_PI_Q14);
    end else begin
      r.orientation = axis_angle(num, den);
    end
    return r;
  endfunction

  // Advance the accumulators by one pixel; return 1 on the frame's last pixel.
  function automatic bit accumulate_pixel(logic p, output moment_rec_t r);
    int unsigned     w, h;
    longint unsigned yv, xv;
    w = dim_eff(cur_width);
    h = dim_eff(cur_height);
    r = '0;
    if (p) begin
      yv = (row_pos < h) ? (h - row_pos) : 1;
      xv = col_pos;
      obj_area  += 1;
      s_row     += yv;
      s_col     += xv;
      s_row_sq  += yv * yv;
      s_col_sq  += xv * xv;
      s_row_col += yv * xv;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        r = frame_summary();
        row_pos = 0;
        obj_area = 0; s_row = 0; s_col = 0;
        s_row_sq = 0; s_col_sq = 0; s_row_col = 0;
        return 1'b1;
      end
      row_pos++;
    end else begin
      col_pos++;
    end
    return 1'b0;
  endfunction

  // Input monitor: predict on every accepted pixel transaction.
  always @(posedge clk_i) begin
    moment_rec_t r;
    if (rst_ni && pix_ch.valid && pix_ch.ready) begin
      if (accumulate_pixel(pix_ch.pixel, r)) begin
        if (typed_pending) begin
          queue_expected(typed_rec);
          typed_pending = 1'b0;
        end else begin
          queue_expected(r);
        end
      end
    end
  end

  // Output monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    moment_rec_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.area, res_ch.centroid_row, res_ch.centroid_col, res_ch.orientation,
              res_ch.empty_frame, res_ch.angle_undefined};
      if (frame_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: area=%0d crow=%0d ccol=%0d ori=%0d empty=%0b undef=%0b",
                   got.area, got.centroid_row, got.centroid_col, got.orientation,
                   got.empty_frame, got.angle_undefined);
      end else begin
        want = frame_results_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp area=%0d crow=%0d ccol=%0d ori=%0d empty=%0b undef=%0b",
                      " | got area=%0d crow=%0d ccol=%0d ori=%0d empty=%0b undef=%0b"},
                     want.area, want.centroid_row, want.centroid_col, want.orientation,
                     want.empty_frame, want.angle_undefined,
                     got.area, got.centroid_row, got.centroid_col, got.orientation,
                     got.empty_frame, got.angle_undefined);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYC) begin
        $display("binary_image_moment_orientation test failed");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, one long hold-off on request.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk_i);
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one pixel, possibly after an idle burst, and hold it until accepted.
  task automatic put_pixel(input logic p);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    do @(posedge clk_i); while (!pix_ch.ready);
    pixels_sent++;
  endtask

  // Pause until every expected result has arrived and the math pipe is drained.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write both frame dimensions while the block is idle.
  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_IDX_WIDTH;
    cfg_data <= w;
    @(posedge clk_i);
    cur_width = w;
    cfg_idx  <= CFG_IDX_HEIGHT;
    cfg_data <= h;
    @(posedge clk_i);
    cur_height = h;
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input fill_e fill, input int pct);
    int unsigned w, h;
    logic        p;
    w = dim_eff(cur_width);
    h = dim_eff(cur_height);
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        case (fill)
          FILL_ZERO: p = 1'b0;
          FILL_ONE:  p = 1'b1;
          FILL_DIAG: p = (r == c);
          FILL_ANTI: p = (r + c == w - 1);
          default:   p = ($urandom_range(0, 99) < pct);
        endcase
        put_pixel(p);
      end
    end
  endtask

  task automatic pick_dims(output logic [CFG_W-1:0] w, output logic [CFG_W-1:0] h);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      w = $urandom_range(1, 8);  h = $urandom_range(1, 8);
    end else if (sel < 95) begin
      w = $urandom_range(1, 12); h = $urandom_range(1, 12);
    end else if (sel < 98) begin
      // long thin frame
      w = $urandom_range(1, 64); h = 1;
      if ($urandom_range(0, 1)) begin w = 1; h = $urandom_range(1, 64); end
    end else begin
      // raw 11-bit value near zero, a zero reads as one; other side a single pixel
      w = $urandom_range(0, 63); h = 0;
      if ($urandom_range(0, 1)) begin h = w; w = 0; end
    end
  endtask

  frame_row_t directed_rows[$];

  initial begin
    logic [CFG_W-1:0] w, h;
    int               pct, nframes;
    bit               held;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_IDX_WIDTH;
    cfg_data      <= '0;
    pix_ch.valid  <= 1'b0;
    pix_ch.pixel  <= 1'b0;
    cur_width     = 11'd1024;
    cur_height    = 11'd1024;
    col_pos = 0; row_pos = 0;
    obj_area = 0; s_row = 0; s_col = 0; s_row_sq = 0; s_col_sq = 0; s_row_col = 0;
    typed_pending = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    held          = 1'b0;
    mismatches    = 0;
    pixels_sent   = 0;
    idle_cycles   = 0;

    // Rows with a typed expectation are the ones that can be worked out by hand:
    // empty frames, a lone pixel (both moments zero) and the two diagonals, which
    // have a zero denominator and give plus or minus pi/4.
    directed_rows = '{
      '{11'd1,    11'd1,    FILL_ZERO, 1'b1, '{21'd0, 19'd0,   19'd0,   15'sd0,      1'b1, 1'b0}},
      '{11'd1,    11'd1,    FILL_ONE,  1'b1, '{21'd1, 19'd256, 19'd0,   15'sd0,      1'b0, 1'b1}},
      '{11'd2,    11'd2,    FILL_DIAG, 1'b1, '{21'd2, 19'd384, 19'd128, -15'sd12868, 1'b0, 1'b0}},
      '{11'd2,    11'd2,    FILL_ANTI, 1'b1, '{21'd2, 19'd384, 19'd128, 15'sd12868,  1'b0, 1'b0}},
      // zero dimensions are taken as one
      '{11'd0,    11'd0,    FILL_ONE,  1'b1, '{21'd1, 19'd256, 19'd0,   15'sd0,      1'b0, 1'b1}},
      '{11'd8,    11'd1,    FILL_ZERO, 1'b1, '{21'd0, 19'd0,   19'd0,   15'sd0,      1'b1, 1'b0}},
      // oversize width clamps to the maximum
      '{11'd2047, 11'd1,    FILL_ONE,  1'b0, '0},
      '{11'd1,    11'd40,   FILL_ONE,  1'b0, '0},
      '{11'd1,    11'd2,    FILL_ONE,  1'b0, '0},
      '{11'd2,    11'd1,    FILL_ONE,  1'b0, '0},
      '{11'd5,    11'd4,    FILL_ONE,  1'b0, '0},
      '{11'd3,    11'd5,    FILL_DIAG, 1'b0, '0},
      '{11'd4,    11'd3,    FILL_ANTI, 1'b0, '0},
      '{11'd3,    11'd3,    FILL_RAND, 1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      set_frame(directed_rows[i].width, directed_rows[i].height);
      typed_pending = directed_rows[i].typed;
      typed_rec     = directed_rows[i].rec;
      send_frame(directed_rows[i].fill, 50);
    end

    // Random phases: new dimensions, then a few frames back to back.
    while (pixels_sent < ITEM_GOAL) begin
      if (pixels_sent >= CALM_AFTER) calm = 1'b1;
      pick_dims(w, h);
      set_frame(w, h);
      if (!held && pixels_sent > ITEM_GOAL / 2) begin
        // Stall the receiver long enough for the frame slots to fill and block input.
        held = 1'b1;
        set_frame(11'd2, 11'd2);
        hold_req = 1'b1;
        repeat (8) send_frame(FILL_RAND, 60);
        continue;
      end
      nframes = $urandom_range(1, 4);
      repeat (nframes) begin
        case ($urandom_range(0, 4))
          0: pct = 0;
          1: pct = 10;
          2: pct = 50;
          3: pct = 90;
          default: pct = 100;
        endcase
        send_frame(FILL_RAND, pct);
      end
    end

    pix_ch.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("binary_image_moment_orientation test passed");
    end else begin
      $display("binary_image_moment_orientation test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bimo_pkg.sv
sv/bimo_if.sv
sv/bimo_accum.sv
sv/bimo_fifo.sv
sv/bimo_math.sv
sv/binary_image_moment_orientation.sv
sim/binary_image_moment_orientation_tb.sv
